[rtl/core/base64_stream_decoder_top_assert.svh]
// Assertion macros shared by the base64 stream decoder RTL.
`ifndef BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`define BASE64_STREAM_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define B64SD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define B64SD_ASSERT(label, clk, rst_n, prop)

`define B64SD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/b64sd_pkg.sv]
// Package with the types, constants and character decoding of the base64 stream decoder.
package b64sd_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 12;
    localparam int MAX_LENGTH_RESET     = 256;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;

    localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
    localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SYM_PLUS       = 6'd62;
    localparam logic [5:0] SYM_MINUS      = 6'd63;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.valid = 1'b1;
        s.value = '0;
        case (c) inside
            [CHAR_UPPER_A:CHAR_UPPER_Z]: s.value = 6'(c - CHAR_UPPER_A);
            [CHAR_LOWER_A:CHAR_LOWER_Z]: s.value = 6'(c - CHAR_LOWER_A) + SYM_LOWER_BASE;
            [CHAR_DIGIT_0:CHAR_DIGIT_9]: s.value = 6'(c - CHAR_DIGIT_0) + SYM_DIGIT_BASE;
            CHAR_PLUS:                   s.value = SYM_PLUS;
            CHAR_MINUS:                  s.value = SYM_MINUS;
            default:                     s.valid = 1'b0;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/base64_stream_decoder_top.sv]
// Top level of the base64 stream decoder: input register, decode step and result register.
// A beat is taken every cycle while the master side does not stall; a result passes through
// the input register and the result register before it appears on the master side.
// Characters outside the alphabet and bytes beyond max_length give no result beat.
// Reset (aresetn low, synchronous) empties both registers, clears the per-string state
// and sets max_length to 256 truncated to LENGTH_WIDTH bits.
`include "base64_stream_decoder_top_assert.svh"

module base64_stream_decoder_top
    import b64sd_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // char_in
    input  logic                    s_tuser,   // kind

    output logic                    m_tvalid,
    input  logic                    m_tready,
    // out_byte, total_length, zero padding
    output logic [((8 + LENGTH_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                    m_tlast,   // is_end
    output logic                    m_tuser,   // terminator_written

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int TDATA_WIDTH = ((8 + LENGTH_WIDTH + 7) / 8) * 8;
    localparam int PAD_WIDTH   = TDATA_WIDTH - 8 - LENGTH_WIDTH;

    logic [LENGTH_WIDTH-1:0] max_length_reg;

    logic                    in_valid_reg, in_valid_next;
    logic                    in_kind_reg;
    logic [7:0]              in_char_reg;

    logic [5:0]              residual_bits_reg, residual_bits_next;
    logic [2:0]              residual_count_reg, residual_count_next;
    logic [LENGTH_WIDTH-1:0] written_count_reg, written_count_next;

    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_byte_reg, out_byte_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_term_reg, out_term_next;
    logic [LENGTH_WIDTH-1:0] out_total_reg, out_total_next;

    logic                    advance;
    logic                    result_valid;
    logic                    room;
    sextet_t                 sym;
    logic [2:0]              count;
    logic [11:0]             acc;
    logic [2:0]              rest;
    logic [11:0]             rest_mask;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(max_length_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= LENGTH_WIDTH'(MAX_LENGTH_RESET);
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            max_length_reg <= pwdata[LENGTH_WIDTH-1:0];
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    // Decode step on the registered beat.
    always_comb begin
        sym       = sextet_of(in_char_reg);
        count     = (residual_count_reg > 3'd6) ? 3'd6 : residual_count_reg;
        acc       = {residual_bits_reg, sym.value};
        rest      = count - 3'd2;
        rest_mask = (12'd1 << rest) - 12'd1;
        room      = written_count_reg < max_length_reg;

        residual_bits_next  = residual_bits_reg;
        residual_count_next = residual_count_reg;
        written_count_next  = written_count_reg;
        result_valid        = 1'b0;
        out_byte_next       = '0;
        out_last_next       = 1'b0;
        out_term_next       = 1'b0;
        out_total_next      = '0;

        if (in_kind_reg == KIND_END) begin
            result_valid        = 1'b1;
            out_last_next       = 1'b1;
            out_term_next       = room;
            out_total_next      = room ? LENGTH_WIDTH'(written_count_reg + 1'b1)
                                       : written_count_reg;
            residual_bits_next  = '0;
            residual_count_next = '0;
            written_count_next  = '0;
        end else if (sym.valid) begin
            if (count < 3'd2) begin
                residual_bits_next  = sym.value;
                residual_count_next = count + 3'd6;
            end else begin
                residual_bits_next  = acc[5:0] & rest_mask[5:0];
                residual_count_next = rest;
                if (room) begin
                    result_valid       = 1'b1;
                    out_byte_next      = 8'(acc >> rest) & BYTE_MASK;
                    written_count_next = LENGTH_WIDTH'(written_count_reg + 1'b1);
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = result_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            residual_bits_reg  <= '0;
            residual_count_reg <= '0;
            written_count_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                residual_bits_reg  <= residual_bits_next;
                residual_count_reg <= residual_count_next;
                written_count_reg  <= written_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_kind_reg <= s_tuser;
            in_char_reg <= s_tdata;
        end
        if (advance && result_valid) begin
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
            out_term_reg  <= out_term_next;
            out_total_reg <= out_total_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_WIDTH{1'b0}}, out_total_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_term_reg;

    `B64SD_ASSERT(a_residual_even, aclk, aresetn, residual_count_reg == 3'd0 || residual_count_reg == 3'd2 || residual_count_reg == 3'd4 || residual_count_reg == 3'd6)
    `B64SD_ASSERT_NEXT(a_end_clears, aclk, aresetn, advance && in_kind_reg == KIND_END, written_count_reg == '0 && residual_count_reg == 3'd0 && residual_bits_reg == 6'd0)
    `B64SD_ASSERT_NEXT(a_byte_counts, aclk, aresetn, advance && result_valid && in_kind_reg == KIND_CHAR, written_count_reg == LENGTH_WIDTH'($past(written_count_reg) + 1'b1))
    `B64SD_ASSERT(a_end_zero_byte, aclk, aresetn, !(out_valid_reg && out_last_reg) || out_byte_reg == 8'd0)

endmodule
